// ----- hw/rtl/i2ctbe_pkg.sv -----
// Types and codes shared by the I2C target bit engine.
package i2ctbe_pkg;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_RX_ADDR   = 7'b0000010,
    PH_RX_BYTE   = 7'b0000100,
    PH_ACK_TO_RX = 7'b0001000,
    PH_ACK_TO_TX = 7'b0010000,
    PH_TX_BYTE   = 7'b0100000,
    PH_RX_ACK    = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_RESTART = 3'd2,
    EV_BYTE    = 3'd3,
    EV_REQUEST = 3'd4,
    EV_STOP    = 3'd5
  } event_code_t;

  localparam logic [3:0] CNT_MAX       = 4'd15;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] RX_ACK_EDGES  = 4'd9;
  localparam logic [3:0] ACK_EDGES     = 4'd1;
  localparam logic [7:0] REQUEST_BYTE  = 8'h01;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       device_ack;
    logic [7:0] device_byte;
  } in_item_t;

  typedef struct packed {
    event_code_t event_code;
    logic [7:0]  event_byte;
    logic        sda_drive;
  } out_item_t;

  typedef struct packed {
    phase_t     bus_phase;
    logic [3:0] bits_in_count;
    logic [3:0] bits_out_count;
    logic [7:0] shift_in_reg;
    logic [7:0] shift_out_reg;
    logic       last_sda;
    logic       last_scl;
    logic       sda_out_reg;
  } eng_state_t;

endpackage

// ----- hw/rtl/i2ctbe_target_bit_engine_top.sv -----
// Top level of the I2C target bit engine: input register, step logic, result register.
// I2C target bit engine. Each item is one sample of SCL and SDA plus the attached
// device's ack and read byte; each item yields exactly one result item holding the
// bus event, its byte and the SDA drive level. Items pass through an input register
// and then a result register before their result is offered on the output, and one
// item is taken every cycle while the output side does not stall. The rate is set
// by the update of the bus state register between items.
module i2c_target_bit_engine_top import i2ctbe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       stage_valid;
  in_item_t   stage_item;
  logic       out_take;
  logic       advance;
  eng_state_t state;
  eng_state_t state_next;
  out_item_t  result;

  assign out_take = ~out_valid | ~out_stall;
  assign in_stall = stage_valid & ~out_take;
  assign advance  = stage_valid & out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (~in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (~in_stall && in_valid) begin
      stage_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  i2ctbe_step u_step (
    .cur  (state),
    .item (stage_item),
    .nxt  (state_next),
    .res  (result)
  );

  i2ctbe_state u_state (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .state_next (state_next),
    .state      (state)
  );

endmodule

// ----- hw/rtl/i2ctbe_step.sv -----
// Next-state and result logic for one line sample of the I2C target engine.
module i2ctbe_step import i2ctbe_pkg::*; (
  input  eng_state_t cur,
  input  in_item_t   item,
  output eng_state_t nxt,
  output out_item_t  res
);

  logic start_cond;
  logic stop_cond;
  logic scl_rise;
  logic scl_fall;
  logic [7:0] shifted;
  logic [3:0] cnt_inc;
  logic [3:0] bout_dec;
  logic [3:0] ack_target;

  assign start_cond = cur.last_sda & ~item.sda_level & cur.last_scl & item.scl_level;
  assign stop_cond  = ~cur.last_sda & item.sda_level & cur.last_scl & item.scl_level;
  assign scl_rise   = ~cur.last_scl & item.scl_level;
  assign scl_fall   = cur.last_scl & ~item.scl_level;
  assign shifted    = {cur.shift_in_reg[6:0], item.sda_level};
  assign cnt_inc    = (cur.bits_in_count < CNT_MAX) ? cur.bits_in_count + 4'd1
                                                    : cur.bits_in_count;
  assign bout_dec   = cur.bits_out_count - 4'd1;
  assign ack_target = (cur.bus_phase == PH_RX_ACK) ? RX_ACK_EDGES : ACK_EDGES;

  always_comb begin
    nxt            = cur;
    res.event_code = EV_NONE;
    res.event_byte = 8'h00;
    if (start_cond) begin
      res.event_code     = (cur.bus_phase != PH_IDLE) ? EV_RESTART : EV_START;
      nxt.bus_phase      = PH_RX_ADDR;
      nxt.bits_in_count  = 4'd0;
      nxt.bits_out_count = 4'd0;
    end else if (stop_cond) begin
      res.event_code = EV_STOP;
      nxt.bus_phase  = PH_IDLE;
    end else if (scl_rise) begin
      nxt.shift_in_reg  = shifted;
      nxt.bits_in_count = cnt_inc;
      case (cur.bus_phase)
        PH_RX_ADDR, PH_RX_BYTE: begin
          if (cnt_inc == BITS_PER_BYTE) begin
            nxt.bits_in_count = 4'd0;
            res.event_code    = EV_BYTE;
            res.event_byte    = shifted;
            if (!item.device_ack) begin
              nxt.bus_phase = PH_IDLE;
            end else if (cur.bus_phase == PH_RX_ADDR && shifted[0]) begin
              nxt.bus_phase = PH_ACK_TO_TX;
            end else begin
              nxt.bus_phase = PH_ACK_TO_RX;
            end
          end
        end
        PH_RX_ACK, PH_ACK_TO_TX: begin
          // master's ack level is ignored: in PH_RX_ACK just release
          if (cur.bus_phase == PH_RX_ACK) begin
            nxt.sda_out_reg = 1'b1;
          end
          if (cnt_inc == ack_target) begin
            nxt.bits_in_count  = 4'd0;
            nxt.bus_phase      = PH_TX_BYTE;
            res.event_code     = EV_REQUEST;
            res.event_byte     = REQUEST_BYTE;
            nxt.shift_out_reg  = item.device_byte;
            nxt.bits_out_count = BITS_PER_BYTE;
          end
        end
        PH_ACK_TO_RX: begin
          if (cnt_inc == ACK_EDGES) begin
            nxt.bits_in_count = 4'd0;
            nxt.bus_phase     = PH_RX_BYTE;
            nxt.sda_out_reg   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (scl_fall) begin
      case (cur.bus_phase)
        PH_RX_ADDR: nxt.sda_out_reg = 1'b1;
        PH_RX_BYTE, PH_RX_ACK: begin
        end
        PH_ACK_TO_TX, PH_ACK_TO_RX: nxt.sda_out_reg = 1'b0;
        PH_TX_BYTE: begin
          nxt.sda_out_reg    = cur.shift_out_reg[7];
          nxt.shift_out_reg  = {cur.shift_out_reg[6:0], 1'b0};
          nxt.bits_out_count = bout_dec;
          if (bout_dec == 4'd0) begin
            nxt.bus_phase = PH_RX_ACK;
          end
        end
        default: nxt.sda_out_reg = 1'b1;
      endcase
    end
    nxt.last_sda  = item.sda_level;
    nxt.last_scl  = item.scl_level;
    res.sda_drive = nxt.sda_out_reg;
  end

endmodule

// ----- hw/rtl/i2ctbe_state.sv -----
// Engine state register, updated once for each processed item.
module i2ctbe_state import i2ctbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  eng_state_t state_next,
  output eng_state_t state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state.bus_phase      <= PH_IDLE;
      state.bits_in_count  <= 4'd0;
      state.bits_out_count <= 4'd0;
      state.shift_in_reg   <= 8'h00;
      state.shift_out_reg  <= 8'h00;
      state.last_sda       <= 1'b1;
      state.last_scl       <= 1'b1;
      state.sda_out_reg    <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the I2C target bit engine: bus line sequences checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2ctbe_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  i2c_target_bit_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // predicted engine state
  phase_t     m_phase;
  logic [3:0] m_bits_in;
  logic [3:0] m_bits_out;
  logic [7:0] m_shift_in;
  logic [7:0] m_shift_out;
  logic       m_sda;
  logic       m_scl;
  logic       m_drive;

  out_item_t expected_events[$];
  int        errors = 0;
  int        items_sent = 0;
  int        seen_events[0:7];
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;
  int        stretch_pct = 0;
  int        dev_ack_pct = 85;
  int        hold_left = 0;
  logic      cur_scl = 1'b1;
  logic      cur_sda = 1'b1;

  task automatic reset_engine_model();
    m_phase     = PH_IDLE;
    m_bits_in   = '0;
    m_bits_out  = '0;
    m_shift_in  = '0;
    m_shift_out = '0;
    m_sda       = 1'b1;
    m_scl       = 1'b1;
    m_drive     = 1'b1;
  endtask

  function automatic out_item_t bus_response(input in_item_t it);
    out_item_t   r;
    event_code_t ev;
    logic [7:0]  eb;
    ev = EV_NONE;
    eb = 8'h00;
    if (m_sda && !it.sda_level && m_scl && it.scl_level) begin
      ev = (m_phase != PH_IDLE) ? EV_RESTART : EV_START;
      m_phase    = PH_RX_ADDR;
      m_bits_in  = '0;
      m_bits_out = '0;
    end else if (!m_sda && it.sda_level && m_scl && it.scl_level) begin
      ev = EV_STOP;
      m_phase = PH_IDLE;
    end else if (!m_scl && it.scl_level) begin
      m_shift_in = {m_shift_in[6:0], it.sda_level};
      if (m_bits_in < CNT_MAX) m_bits_in++;
      case (m_phase)
        PH_RX_ADDR, PH_RX_BYTE: if (m_bits_in == BITS_PER_BYTE) begin
          m_bits_in = '0;
          ev = EV_BYTE;
          eb = m_shift_in;
          if (!it.device_ack) m_phase = PH_IDLE;
          else if (m_phase == PH_RX_ADDR && m_shift_in[0]) m_phase = PH_ACK_TO_TX;
          else m_phase = PH_ACK_TO_RX;
        end
        PH_RX_ACK, PH_ACK_TO_TX: begin
          // the master's acknowledge level is ignored, just release
          if (m_phase == PH_RX_ACK) m_drive = 1'b1;
          if (m_bits_in == ((m_phase == PH_RX_ACK) ? RX_ACK_EDGES : ACK_EDGES)) begin
            m_bits_in   = '0;
            m_phase     = PH_TX_BYTE;
            ev          = EV_REQUEST;
            eb          = REQUEST_BYTE;
            m_shift_out = it.device_byte;
            m_bits_out  = BITS_PER_BYTE;
          end
        end
        PH_ACK_TO_RX: if (m_bits_in == ACK_EDGES) begin
          m_bits_in = '0;
          m_phase   = PH_RX_BYTE;
          m_drive   = 1'b1;
        end
        default: ;
      endcase
    end else if (m_scl && !it.scl_level) begin
      case (m_phase)
        PH_RX_ADDR: m_drive = 1'b1;
        PH_RX_BYTE, PH_RX_ACK: ;
        PH_ACK_TO_TX, PH_ACK_TO_RX: m_drive = 1'b0;
        PH_TX_BYTE: begin
          m_drive     = m_shift_out[7];
          m_shift_out = m_shift_out << 1;
          m_bits_out  = m_bits_out - 4'd1;
          if (m_bits_out == 4'd0) m_phase = PH_RX_ACK;
        end
        default: m_drive = 1'b1;
      endcase
    end
    m_sda = it.sda_level;
    m_scl = it.scl_level;
    r.event_code = ev;
    r.event_byte = eb;
    r.sda_drive  = m_drive;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %0s", $realtime, msg);
    errors++;
  endtask

  // receiver side: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected, event %0d",
                                  out_data.event_code));
      end else begin
        want = expected_events.pop_front();
        seen_events[int'(want.event_code)]++;
        if (out_data.event_code !== want.event_code)
          report_mismatch($sformatf("event_code got %0d want %0d",
                                    out_data.event_code, want.event_code));
        if (out_data.event_byte !== want.event_byte)
          report_mismatch($sformatf("event_byte got %02h want %02h",
                                    out_data.event_byte, want.event_byte));
        if (out_data.sda_drive !== want.sda_drive)
          report_mismatch($sformatf("sda_drive got %0b want %0b",
                                    out_data.sda_drive, want.sda_drive));
      end
    end
  end

  // call at a falling edge; returns at a falling edge after the item is taken
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_events.push_back(bus_response(it));
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic rand_ack();
    return ($urandom_range(99) < dev_ack_pct);
  endfunction

  task automatic send_line(input logic scl, input logic sda, input logic ack,
                           input logic [7:0] dbyte);
    in_item_t it;
    it.scl_level   = scl;
    it.sda_level   = sda;
    it.device_ack  = ack;
    it.device_byte = dbyte;
    cur_scl = scl;
    cur_sda = sda;
    send_item(it);
  endtask

  // one SCL clock; ack and dbyte go with the rising-edge sample
  task automatic clock_bit(input logic b, input logic ack, input logic [7:0] dbyte);
    if (cur_scl) send_line(1'b0, cur_sda, rand_ack(), 8'($urandom));
    if (cur_sda != b) send_line(1'b0, b, rand_ack(), 8'($urandom));
    while ($urandom_range(99) < stretch_pct) send_line(1'b0, b, rand_ack(), 8'($urandom));
    send_line(1'b1, b, ack, dbyte);
    while ($urandom_range(99) < stretch_pct) send_line(1'b1, b, rand_ack(), 8'($urandom));
  endtask

  task automatic start_cond();
    if (!cur_sda) begin
      if (cur_scl) send_line(1'b0, 1'b0, rand_ack(), 8'($urandom));
      send_line(1'b0, 1'b1, rand_ack(), 8'($urandom));
    end
    if (!cur_scl) send_line(1'b1, 1'b1, rand_ack(), 8'($urandom));
    send_line(1'b1, 1'b0, rand_ack(), 8'($urandom));
  endtask

  task automatic stop_cond();
    if (cur_sda) begin
      if (cur_scl) send_line(1'b0, 1'b1, rand_ack(), 8'($urandom));
      send_line(1'b0, 1'b0, rand_ack(), 8'($urandom));
    end
    if (!cur_scl) send_line(1'b1, 1'b0, rand_ack(), 8'($urandom));
    send_line(1'b1, 1'b1, rand_ack(), 8'($urandom));
  endtask

  // eight data clocks MSB first, then the acknowledge clock
  task automatic send_byte(input logic [7:0] v, input logic ack, input logic [7:0] dbyte,
                           input logic master_ack);
    for (int i = 7; i >= 0; i--) clock_bit(v[i], (i == 0) ? ack : rand_ack(), 8'($urandom));
    clock_bit(master_ack, rand_ack(), dbyte);
  endtask

  task automatic random_transfer();
    logic [7:0] addr;
    int         nbytes;
    addr   = 8'($urandom);
    nbytes = int'($urandom_range(0, 3));
    start_cond();
    send_byte(addr, rand_ack(), 8'($urandom), 1'($urandom_range(1)));
    if (addr[0]) begin
      repeat (9 * nbytes) clock_bit(1'($urandom_range(1)), rand_ack(), 8'($urandom));
    end else begin
      repeat (nbytes) send_byte(8'($urandom), rand_ack(), 8'($urandom),
                                1'($urandom_range(1)));
    end
    // leave some transfers open so the next START is a repeated one
    if ($urandom_range(99) < 75) stop_cond();
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
  endtask

  task automatic test_bus_conditions();
    start_cond();
    clock_bit(1'b0, 1'b1, 8'h00);
    start_cond();
    stop_cond();
  endtask

  task automatic test_address_nack();
    start_cond();
    send_byte(8'hFF, 1'b0, 8'hFF, 1'b1);
    // engine is idle now: this edge only counts
    clock_bit(1'b0, 1'b1, 8'h00);
    stop_cond();
  endtask

  task automatic test_read_continuation();
    start_cond();
    send_byte(8'h01, 1'b1, 8'hFF, 1'b0);
    repeat (8) clock_bit(1'($urandom_range(1)), 1'b0, 8'hFF);
    // ninth rising edge fetches the next byte
    clock_bit(1'b1, 1'b0, 8'h00);
    stop_cond();
  endtask

  task automatic test_random_mix(input int gap_pct, input int stall_pct, input int n);
    int stop_at;
    int pick;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    stretch_pct    = 30;
    stop_at        = items_sent + n;
    while (items_sent < stop_at) begin
      pick = int'($urandom_range(99));
      dev_ack_pct = int'($urandom_range(70, 100));
      if (pick < 70) begin
        random_transfer();
      end else if (pick < 80) begin
        start_cond();
        repeat ($urandom_range(1, 12))
          clock_bit(1'($urandom_range(1)), rand_ack(), 8'($urandom));
        if ($urandom_range(1)) stop_cond();
      end else if (pick < 90) begin
        repeat ($urandom_range(4, 30))
          send_line(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    8'($urandom));
      end else begin
        // idle clocks, mostly enough to saturate the input bit counter
        stop_cond();
        repeat ($urandom_range(14, 20))
          clock_bit(1'($urandom_range(1)), rand_ack(), 8'($urandom));
      end
    end
    wait_drain();
  endtask

  task automatic test_output_hold();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_left      = 80;
    random_transfer();
    random_transfer();
    wait_drain();
  endtask

  initial begin
    foreach (seen_events[i]) seen_events[i] = 0;
    reset_engine_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_bus_conditions();
    test_address_nack();
    test_read_continuation();
    wait_drain();
    test_random_mix(12, 49, 500);
    test_output_hold();
    test_random_mix(49, 12, 500);
    test_random_mix(0, 0, 500);

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d line samples: %0d starts, %0d restarts, %0d bytes, %0d requests, %0d stops",
             items_sent, seen_events[EV_START], seen_events[EV_RESTART],
             seen_events[EV_BYTE], seen_events[EV_REQUEST], seen_events[EV_STOP]);
    $display("Idling on either side, none at all, and one long output hold; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("PASS i2c_target_bit_engine_top");
    end else begin
      $display("FAIL i2c_target_bit_engine_top");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL i2c_target_bit_engine_top");
    $finish;
  end

endmodule
